// ----- hw/rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// shared types and constants of the cycling speed and cadence calculator
// ----------------------------------------------------------------------------
package csc_pkg;

   // request codes on req_type
   typedef enum logic [1:0] {
      REQ_SAMPLE        = 2'd0,
      REQ_SESSION_RESET = 2'd1,
      REQ_TIMEOUT       = 2'd2
   } req_code_type;

   // field widths
   localparam int unsigned CIRC_W     = 12;
   localparam int unsigned WREVS_W    = 32;
   localparam int unsigned CREVS_W    = 16;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned VALUE_W    = 16;

   // revolution deltas that pass the garbage test fit these widths
   localparam int unsigned WHEEL_DR_W = 17;
   localparam int unsigned CRANK_DR_W = 11;
   localparam int unsigned PROD_W     = WHEEL_DR_W + CIRC_W;

   // divider operand widths
   localparam int unsigned NUM_W      = 42;
   localparam int unsigned DEN_W      = 21;
   localparam int unsigned QUO_W      = VALUE_W;
   localparam int unsigned CNT_W      = $clog2(QUO_W);

   // garbage limits and reset value of the circumference register
   localparam logic [WREVS_W-1:0] WHEEL_GARBAGE = 32'd100000;
   localparam logic [CREVS_W-1:0] CRANK_GARBAGE = 16'd2000;
   localparam logic [CIRC_W-1:0]  CIRC_RESET    = 12'd2105;

   // divider start request
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   // divider completion
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

   // one result word
   typedef struct packed {
      logic [VALUE_W-1:0] speed;
      logic [VALUE_W-1:0] cadence;
      logic               from_timeout;
   } result_type;

endpackage

// ----- hw/rtl/csc_divider.sv -----
// ----------------------------------------------------------------------------
// csc_divider
// saturating restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module csc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  csc_pkg::div_req_type div_req,
   output csc_pkg::div_rsp_type div_rsp
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_ITER,
      D_DONE
   } div_state_type;

   div_state_type                   state_ff;
   logic [csc_pkg::NUM_W-1:0]       num_ff;
   logic [csc_pkg::DEN_W-1:0]       den_ff;
   logic [csc_pkg::DEN_W-1:0]       rem_ff;
   logic [csc_pkg::QUO_W-1:0]       low_ff;
   logic [csc_pkg::CNT_W-1:0]       cnt_ff;

   logic [csc_pkg::NUM_W-csc_pkg::QUO_W-1:0] num_high;
   logic                            sat;
   logic [csc_pkg::DEN_W:0]         trial;
   logic                            fits;

   // quotient would exceed the result field
   assign num_high = num_ff[csc_pkg::NUM_W-1:csc_pkg::QUO_W];
   assign sat      = num_high >= (csc_pkg::NUM_W-csc_pkg::QUO_W)'(den_ff);

   // one restoring step
   assign trial = {rem_ff, low_ff[csc_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (div_req.start) begin
                  num_ff   <= div_req.num;
                  den_ff   <= div_req.den;
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               cnt_ff <= '0;
               if (sat) begin
                  low_ff   <= '1;
                  state_ff <= D_DONE;
               end else begin
                  rem_ff   <= num_ff[csc_pkg::QUO_W +: csc_pkg::DEN_W];
                  low_ff   <= num_ff[csc_pkg::QUO_W-1:0];
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               if (fits) begin
                  rem_ff <= csc_pkg::DEN_W'(trial - {1'b0, den_ff});
               end else begin
                  rem_ff <= trial[csc_pkg::DEN_W-1:0];
               end
               low_ff <= {low_ff[csc_pkg::QUO_W-2:0], fits};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == csc_pkg::CNT_W'(csc_pkg::QUO_W - 1)) begin
                  state_ff <= D_DONE;
               end
            end
            D_DONE: begin
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign div_rsp.done = (state_ff == D_DONE);
   assign div_rsp.quot = low_ff;

endmodule

// ----- hw/rtl/csc_core.sv -----
// ----------------------------------------------------------------------------
// csc_core
// request sequencer: history, deltas, operand setup and use of the divider
// ----------------------------------------------------------------------------
module csc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [csc_pkg::CIRC_W-1:0]    circ,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic                          has_wheel,
   input  logic [csc_pkg::WREVS_W-1:0]   wheel_revs,
   input  logic [csc_pkg::TIME_W-1:0]    wheel_event_time,
   input  logic                          has_crank,
   input  logic [csc_pkg::CREVS_W-1:0]   crank_revs,
   input  logic [csc_pkg::TIME_W-1:0]    crank_event_time,
   output logic                          res_valid,
   input  logic                          res_ready,
   output csc_pkg::result_type           res,
   output csc_pkg::div_req_type          div_req,
   input  csc_pkg::div_rsp_type          div_rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_MUL,
      S_SPD_GO,
      S_SPD_WAIT,
      S_CAD_GO,
      S_CAD_WAIT,
      S_DONE
   } core_state_type;

   core_state_type                      state_ff;

   // captured request word
   logic                                has_wheel_ff;
   logic [csc_pkg::WREVS_W-1:0]         wrevs_ff;
   logic [csc_pkg::TIME_W-1:0]          wtime_ff;
   logic                                has_crank_ff;
   logic [csc_pkg::CREVS_W-1:0]         crevs_ff;
   logic [csc_pkg::TIME_W-1:0]          ctime_ff;

   // history
   logic                                wheel_hist_ff;
   logic [csc_pkg::WREVS_W-1:0]         prev_wheel_count_ff;
   logic [csc_pkg::TIME_W-1:0]          prev_wheel_time_ff;
   logic                                crank_hist_ff;
   logic [csc_pkg::CREVS_W-1:0]         prev_crank_count_ff;
   logic [csc_pkg::TIME_W-1:0]          prev_crank_time_ff;
   logic [csc_pkg::VALUE_W-1:0]         last_speed_ff;
   logic [csc_pkg::VALUE_W-1:0]         last_cadence_ff;

   // operands and results
   logic [csc_pkg::WHEEL_DR_W-1:0]      w_dr_ff;
   logic [csc_pkg::TIME_W-1:0]          w_dt_ff;
   logic [csc_pkg::CRANK_DR_W-1:0]      c_dr_ff;
   logic [csc_pkg::TIME_W-1:0]          c_dt_ff;
   logic                                spd_go_ff;
   logic                                cad_go_ff;
   logic [csc_pkg::PROD_W-1:0]          prod_ff;
   logic [csc_pkg::VALUE_W-1:0]         speed_ff;
   logic [csc_pkg::VALUE_W-1:0]         cadence_ff;
   logic                                from_timeout_ff;

   logic [csc_pkg::WREVS_W-1:0]         w_dr;
   logic [csc_pkg::TIME_W-1:0]          w_dt;
   logic [csc_pkg::CREVS_W-1:0]         c_dr;
   logic [csc_pkg::TIME_W-1:0]          c_dt;
   logic                                spd_go;
   logic                                cad_go;
   logic [csc_pkg::NUM_W-1:0]           spd_num;
   logic [csc_pkg::DEN_W-1:0]           spd_den;
   logic [csc_pkg::CRANK_DR_W+3:0]      cad_x15;
   logic [csc_pkg::NUM_W-1:0]           cad_num;
   logic [csc_pkg::DEN_W-1:0]           cad_den;

   // wraparound deltas and garbage tests
   assign w_dr   = wrevs_ff - prev_wheel_count_ff;
   assign w_dt   = wtime_ff - prev_wheel_time_ff;
   assign c_dr   = crevs_ff - prev_crank_count_ff;
   assign c_dt   = ctime_ff - prev_crank_time_ff;
   assign spd_go = has_wheel_ff && wheel_hist_ff && (w_dt != '0)
                   && (w_dr < csc_pkg::WHEEL_GARBAGE);
   assign cad_go = has_crank_ff && crank_hist_ff && (c_dt != '0)
                   && (c_dr < csc_pkg::CRANK_GARBAGE);

   // speed: dr*circ*9216 over dt*25, with 9216 = 8192 + 1024
   assign spd_num = {prod_ff, 13'b0} + {3'b0, prod_ff, 10'b0};
   assign spd_den = {1'b0, w_dt_ff, 4'b0} + {2'b0, w_dt_ff, 3'b0} + {5'b0, w_dt_ff};

   // cadence: dr*983040 over dt, with 983040 = 15 * 65536
   assign cad_x15 = {c_dr_ff, 4'b0} - {4'b0, c_dr_ff};
   assign cad_num = {11'b0, cad_x15, 16'b0};
   assign cad_den = {5'b0, c_dt_ff};

   // divider request
   always_comb begin
      div_req.start = (state_ff == S_SPD_GO) || (state_ff == S_CAD_GO);
      div_req.num   = (state_ff == S_CAD_GO) ? cad_num : spd_num;
      div_req.den   = (state_ff == S_CAD_GO) ? cad_den : spd_den;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res.speed        = speed_ff;
   assign res.cadence      = cadence_ff;
   assign res.from_timeout = from_timeout_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         wheel_hist_ff   <= 1'b0;
         crank_hist_ff   <= 1'b0;
         last_speed_ff   <= '0;
         last_cadence_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               has_wheel_ff <= has_wheel;
               wrevs_ff     <= wheel_revs;
               wtime_ff     <= wheel_event_time;
               has_crank_ff <= has_crank;
               crevs_ff     <= crank_revs;
               ctime_ff     <= crank_event_time;
               if (req_valid) begin
                  case (req_type)
                     csc_pkg::REQ_SAMPLE: begin
                        state_ff <= S_PREP;
                     end
                     csc_pkg::REQ_SESSION_RESET: begin
                        wheel_hist_ff <= 1'b0;
                        crank_hist_ff <= 1'b0;
                     end
                     csc_pkg::REQ_TIMEOUT: begin
                        // only report when something was moving
                        if ((last_speed_ff != '0) || (last_cadence_ff != '0)) begin
                           wheel_hist_ff   <= 1'b0;
                           crank_hist_ff   <= 1'b0;
                           last_speed_ff   <= '0;
                           last_cadence_ff <= '0;
                           speed_ff        <= '0;
                           cadence_ff      <= '0;
                           from_timeout_ff <= 1'b1;
                           state_ff        <= S_DONE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_PREP: begin
               w_dr_ff         <= w_dr[csc_pkg::WHEEL_DR_W-1:0];
               w_dt_ff         <= w_dt;
               c_dr_ff         <= c_dr[csc_pkg::CRANK_DR_W-1:0];
               c_dt_ff         <= c_dt;
               spd_go_ff       <= spd_go;
               cad_go_ff       <= cad_go;
               from_timeout_ff <= 1'b0;
               speed_ff        <= has_wheel_ff ? '0 : last_speed_ff;
               cadence_ff      <= has_crank_ff ? '0 : last_cadence_ff;
               if (has_wheel_ff) begin
                  prev_wheel_count_ff <= wrevs_ff;
                  prev_wheel_time_ff  <= wtime_ff;
                  wheel_hist_ff       <= 1'b1;
               end
               if (has_crank_ff) begin
                  prev_crank_count_ff <= crevs_ff;
                  prev_crank_time_ff  <= ctime_ff;
                  crank_hist_ff       <= 1'b1;
               end
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff <= csc_pkg::PROD_W'(w_dr_ff) * csc_pkg::PROD_W'(circ);
               if (spd_go_ff) begin
                  state_ff <= S_SPD_GO;
               end else if (cad_go_ff) begin
                  state_ff <= S_CAD_GO;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SPD_GO: begin
               state_ff <= S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
               if (div_rsp.done) begin
                  speed_ff <= div_rsp.quot;
                  state_ff <= cad_go_ff ? S_CAD_GO : S_DONE;
               end
            end
            S_CAD_GO: begin
               state_ff <= S_CAD_WAIT;
            end
            S_CAD_WAIT: begin
               if (div_rsp.done) begin
                  cadence_ff <= div_rsp.quot;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (res_ready) begin
                  last_speed_ff   <= speed_ff;
                  last_cadence_ff <= cadence_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/csc_speed_cadence_calc.sv -----
// ----------------------------------------------------------------------------
// csc_speed_cadence_calc
// cycling speed and cadence from cumulative revolution counts and event times
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+----------------------------
//   req_    | in        | req_valid / req_ready  | request type, wheel, crank
//   rsp_    | out       | rsp_valid / rsp_ready  | speed, cadence, timeout flag
//   csr_    | in        | csr_valid / csr_ready  | wheel circumference in mm
//
// a sample holds req_ready low while the core prepares the deltas, multiplies and runs
// up to two divisions (start, check, 16 quotient bits, done), speed then cadence, on the
// shared one-bit-per-cycle divider. a session reset keeps req_ready high; a timeout that
// reports, like a sample, lowers it until its word enters the output register.
// reset clears history and last values and loads the default circumference.
// the core waits in its done state while the output register is full and not taken.
// ----------------------------------------------------------------------------
module csc_speed_cadence_calc (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        req_has_wheel,
   input  logic [31:0] req_wheel_revs,
   input  logic [15:0] req_wheel_event_time,
   input  logic        req_has_crank,
   input  logic [15:0] req_crank_revs,
   input  logic [15:0] req_crank_event_time,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_speed_centi_kph,
   output logic [15:0] rsp_cadence_sixteenth_rpm,
   output logic        rsp_from_timeout,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_wheel_circumference_mm
);

   logic [csc_pkg::CIRC_W-1:0]  circ_ff;
   logic                        rsp_valid_ff;
   csc_pkg::result_type         rsp_word_ff;
   logic                        res_valid;
   logic                        res_ready;
   csc_pkg::result_type         res;
   csc_pkg::div_req_type        div_req;
   csc_pkg::div_rsp_type        div_rsp;

   // circumference register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= csc_pkg::CIRC_RESET;
      end else if (csr_valid) begin
         circ_ff <= csr_wheel_circumference_mm;
      end
   end

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_speed_centi_kph       = rsp_word_ff.speed;
   assign rsp_cadence_sixteenth_rpm = rsp_word_ff.cadence;
   assign rsp_from_timeout          = rsp_word_ff.from_timeout;

   // sequencer
   csc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .circ             (circ_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .has_wheel        (req_has_wheel),
      .wheel_revs       (req_wheel_revs),
      .wheel_event_time (req_wheel_event_time),
      .has_crank        (req_has_crank),
      .crank_revs       (req_crank_revs),
      .crank_event_time (req_crank_event_time),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res),
      .div_req          (div_req),
      .div_rsp          (div_rsp)
   );

   // shared divider
   csc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// ----- hw/rtl/csc_checker.sv -----
// ----------------------------------------------------------------------------
// csc_checker
// port-level checks of the speed and cadence calculator
// ----------------------------------------------------------------------------
module csc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_speed_centi_kph,
   input logic [15:0] rsp_cadence_sixteenth_rpm,
   input logic        rsp_from_timeout
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_centi_kph)
         && $stable(rsp_cadence_sixteenth_rpm) && $stable(rsp_from_timeout))
      else $error("response word changed while stalled");

   // a timeout word carries zero speed and cadence
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_timeout |->
         rsp_speed_centi_kph == '0 && rsp_cadence_sixteenth_rpm == '0)
      else $error("timeout word with nonzero value");

   // a measurement sample keeps the block busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == csc_pkg::REQ_SAMPLE) |=> !req_ready)
      else $error("ready right after a sample");

endmodule

bind csc_speed_cadence_calc csc_checker u_csc_checker (
   .clock                     (clock),
   .reset                     (reset),
   .req_valid                 (req_valid),
   .req_ready                 (req_ready),
   .req_type                  (req_type),
   .rsp_valid                 (rsp_valid),
   .rsp_ready                 (rsp_ready),
   .rsp_speed_centi_kph       (rsp_speed_centi_kph),
   .rsp_cadence_sixteenth_rpm (rsp_cadence_sixteenth_rpm),
   .rsp_from_timeout          (rsp_from_timeout)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the cycling speed and cadence calculator word by word against its
// own predictor or typed-in expectations: a short table of directed requests,
// then phases of random sample streams at several wheel circumferences, with
// random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;

   // request code with no meaning, the block drops it
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;

   localparam int unsigned SETTLE_CYCLES   = 64;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned ITEMS_PER_PHASE = 305;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [1:0]  kind;
      logic        has_wheel;
      logic [31:0] wheel_revs;
      logic [15:0] wheel_time;
      logic        has_crank;
      logic [15:0] crank_revs;
      logic [15:0] crank_time;
   } csc_request_type;

   typedef struct {
      csc_request_type     req;
      bit                  typed;
      int unsigned         count;
      csc_pkg::result_type res;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = csc_pkg::REQ_SAMPLE;
   logic        req_has_wheel = 1'b0;
   logic [31:0] req_wheel_revs = '0;
   logic [15:0] req_wheel_event_time = '0;
   logic        req_has_crank = 1'b0;
   logic [15:0] req_crank_revs = '0;
   logic [15:0] req_crank_event_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_speed_centi_kph;
   logic [15:0] rsp_cadence_sixteenth_rpm;
   logic        rsp_from_timeout;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_wheel_circumference_mm = csc_pkg::CIRC_RESET;

   // typed-in expectation riding along with the word on the request side
   bit                  row_typed = 1'b0;
   int unsigned         row_count = 0;
   csc_pkg::result_type row_result = '0;

   // predictor state
   logic [11:0] model_circ = csc_pkg::CIRC_RESET;
   logic        model_wheel_valid = 1'b0;
   logic [31:0] model_wheel_count = '0;
   logic [15:0] model_wheel_time = '0;
   logic        model_crank_valid = 1'b0;
   logic [15:0] model_crank_count = '0;
   logic [15:0] model_crank_time = '0;
   logic [15:0] model_speed = '0;
   logic [15:0] model_cadence = '0;

   // stimulus trackers for well-formed streams
   logic [31:0] gen_wheel_revs = '0;
   logic [15:0] gen_wheel_time = '0;
   logic [15:0] gen_crank_revs = '0;
   logic [15:0] gen_crank_time = '0;

   csc_pkg::result_type expected_readings[$];
   directed_row_type    directed_rows[$];
   int unsigned         mismatches = 0;
   int unsigned         readings_seen = 0;
   int unsigned         quiet_cycles = 0;
   bit                  no_gaps = 1'b0;
   bit                  hold_off_done = 1'b0;

   csc_speed_cadence_calc dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_type                  (req_type),
      .req_has_wheel             (req_has_wheel),
      .req_wheel_revs            (req_wheel_revs),
      .req_wheel_event_time      (req_wheel_event_time),
      .req_has_crank             (req_has_crank),
      .req_crank_revs            (req_crank_revs),
      .req_crank_event_time      (req_crank_event_time),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_speed_centi_kph       (rsp_speed_centi_kph),
      .rsp_cadence_sixteenth_rpm (rsp_cadence_sixteenth_rpm),
      .rsp_from_timeout          (rsp_from_timeout),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_wheel_circumference_mm(csr_wheel_circumference_mm)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // truncated quotient, saturated to the value width
   function automatic logic [15:0] quotient_sat(input logic [63:0] num,
                                                input logic [63:0] den);
      logic [63:0] q;
      q = num / den;
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // predicts speed and cadence for one accepted word and updates history
   task automatic predict_reading(input csc_request_type it, output int unsigned n,
                                  output csc_pkg::result_type r);
      logic [31:0] wheel_dr;
      logic [15:0] wheel_dt;
      logic [15:0] crank_dr;
      logic [15:0] crank_dt;
      logic [15:0] speed;
      logic [15:0] cadence;
      n = 0;
      r = '0;
      case (it.kind)
         csc_pkg::REQ_SESSION_RESET: begin
            model_wheel_valid = 1'b0;
            model_crank_valid = 1'b0;
         end
         csc_pkg::REQ_TIMEOUT: begin
            if (model_speed != 0 || model_cadence != 0) begin
               model_speed = '0;
               model_cadence = '0;
               model_wheel_valid = 1'b0;
               model_crank_valid = 1'b0;
               r.from_timeout = 1'b1;
               n = 1;
            end
         end
         csc_pkg::REQ_SAMPLE: begin
            // wheel side
            speed = model_speed;
            if (it.has_wheel) begin
               speed = '0;
               wheel_dr = it.wheel_revs - model_wheel_count;
               wheel_dt = it.wheel_time - model_wheel_time;
               if (model_wheel_valid && wheel_dt != 0
                   && wheel_dr < csc_pkg::WHEEL_GARBAGE)
                  speed = quotient_sat(64'(wheel_dr) * 64'(model_circ) * 64'd9216,
                                       64'(wheel_dt) * 64'd25);
               model_wheel_count = it.wheel_revs;
               model_wheel_time = it.wheel_time;
               model_wheel_valid = 1'b1;
            end
            // crank side
            cadence = model_cadence;
            if (it.has_crank) begin
               cadence = '0;
               crank_dr = it.crank_revs - model_crank_count;
               crank_dt = it.crank_time - model_crank_time;
               if (model_crank_valid && crank_dt != 0
                   && crank_dr < csc_pkg::CRANK_GARBAGE)
                  cadence = quotient_sat(64'(crank_dr) * 64'd983040, 64'(crank_dt));
               model_crank_count = it.crank_revs;
               model_crank_time = it.crank_time;
               model_crank_valid = 1'b1;
            end
            model_speed = speed;
            model_cadence = cadence;
            r.speed = speed;
            r.cadence = cadence;
            n = 1;
         end
         default: ;
      endcase
   endtask

   // gap length: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // event time step in ticks, unchanged time and wrap included
   function automatic logic [15:0] random_tick_delta();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return 16'($urandom_range(64, 3000));
      else if (r < 90)
         return 16'($urandom_range(1, 16));
      else if (r < 95)
         return 16'd0;
      return 16'($urandom());
   endfunction

   task automatic add_row(input logic [1:0] kind, input int unsigned hw,
                          input logic [31:0] wrevs, input logic [15:0] wtime,
                          input int unsigned hc,
                          input logic [15:0] crevs, input logic [15:0] ctime,
                          input int unsigned typed, input int unsigned count,
                          input int unsigned speed, input int unsigned cadence,
                          input int unsigned tmo);
      directed_row_type row;
      row.req.kind = kind;
      row.req.has_wheel = 1'(hw);
      row.req.wheel_revs = wrevs;
      row.req.wheel_time = wtime;
      row.req.has_crank = 1'(hc);
      row.req.crank_revs = crevs;
      row.req.crank_time = ctime;
      row.typed = 1'(typed);
      row.count = count;
      row.res.speed = 16'(speed);
      row.res.cadence = 16'(cadence);
      row.res.from_timeout = 1'(tmo);
      directed_rows.push_back(row);
   endtask

   // mostly well-formed sample streams with random content, some noise
   task automatic make_random_request(output csc_request_type it);
      int unsigned pick;
      int unsigned r;
      pick = $urandom_range(0, 99);
      it.kind = csc_pkg::REQ_SAMPLE;
      it.has_wheel = 1'($urandom_range(0, 1));
      it.wheel_revs = $urandom();
      it.wheel_time = 16'($urandom());
      it.has_crank = 1'($urandom_range(0, 1));
      it.crank_revs = 16'($urandom());
      it.crank_time = 16'($urandom());
      if (pick < 3) begin
         // new session starts from fresh counters
         it.kind = csc_pkg::REQ_SESSION_RESET;
         gen_wheel_revs = $urandom();
         gen_wheel_time = 16'($urandom());
         gen_crank_revs = 16'($urandom());
         gen_crank_time = 16'($urandom());
      end else if (pick < 7) begin
         it.kind = csc_pkg::REQ_TIMEOUT;
      end else if (pick < 9) begin
         it.kind = REQ_UNDEFINED;
      end else if (pick >= 14) begin
         it.has_wheel = ($urandom_range(0, 9) != 0);
         it.has_crank = ($urandom_range(0, 9) != 0);
         if (it.has_wheel) begin
            r = $urandom_range(0, 99);
            if (r < 88)
               gen_wheel_revs += $urandom_range(0, 12);
            else if (r < 93)
               gen_wheel_revs += $urandom_range(99990, 99999);
            else if (r < 97)
               gen_wheel_revs += $urandom_range(100000, 100010);
            else
               gen_wheel_revs += $urandom();
            gen_wheel_time += random_tick_delta();
            it.wheel_revs = gen_wheel_revs;
            it.wheel_time = gen_wheel_time;
         end
         if (it.has_crank) begin
            r = $urandom_range(0, 99);
            if (r < 88)
               gen_crank_revs += 16'($urandom_range(0, 5));
            else if (r < 93)
               gen_crank_revs += 16'($urandom_range(1990, 1999));
            else if (r < 97)
               gen_crank_revs += 16'($urandom_range(2000, 2010));
            else
               gen_crank_revs += 16'($urandom());
            gen_crank_time += random_tick_delta();
            it.crank_revs = gen_crank_revs;
            it.crank_time = gen_crank_time;
         end
      end
   endtask

   // offers one word and returns at the edge that accepts it
   task automatic offer_request(input csc_request_type it, input bit typed,
                                input int unsigned count, input csc_pkg::result_type res);
      int unsigned gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_has_wheel <= it.has_wheel;
      req_wheel_revs <= it.wheel_revs;
      req_wheel_event_time <= it.wheel_time;
      req_has_crank <= it.has_crank;
      req_crank_revs <= it.crank_revs;
      req_crank_event_time <= it.crank_time;
      row_typed <= typed;
      row_count <= count;
      row_result <= res;
      do @(posedge clock); while (!req_ready);
   endtask

   // stops offering and waits for every outstanding reading
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   // circumference write, only with the block idle
   task automatic write_circumference(input logic [11:0] mm);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wheel_circumference_mm <= mm;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // request and register side monitor, feeds the predictor
   always @(posedge clock) begin : request_monitor
      csc_request_type     it;
      int unsigned         n;
      csc_pkg::result_type r;
      if (!reset && req_valid && req_ready) begin
         it.kind = req_type;
         it.has_wheel = req_has_wheel;
         it.wheel_revs = req_wheel_revs;
         it.wheel_time = req_wheel_event_time;
         it.has_crank = req_has_crank;
         it.crank_revs = req_crank_revs;
         it.crank_time = req_crank_event_time;
         predict_reading(it, n, r);
         if (row_typed) begin
            n = row_count;
            r = row_result;
         end
         if (n != 0)
            expected_readings.push_back(r);
      end
      if (!reset && csr_valid && csr_ready)
         model_circ = csr_wheel_circumference_mm;
   end

   // result side monitor, compares against the oldest expectation
   always @(posedge clock) begin : reading_checker
      csc_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         readings_seen++;
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %0d %0d %0d", $time,
                     rsp_speed_centi_kph, rsp_cadence_sixteenth_rpm, rsp_from_timeout);
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_speed_centi_kph !== want.speed) begin
               $display("%0t: speed expected %0d actual %0d", $time, want.speed,
                        rsp_speed_centi_kph);
               mismatches++;
            end
            if (rsp_cadence_sixteenth_rpm !== want.cadence) begin
               $display("%0t: cadence expected %0d actual %0d", $time, want.cadence,
                        rsp_cadence_sixteenth_rpm);
               mismatches++;
            end
            if (rsp_from_timeout !== want.from_timeout) begin
               $display("%0t: from_timeout expected %0d actual %0d", $time,
                        want.from_timeout, rsp_from_timeout);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result sink: random stalls, one long hold-off while the sender keeps going
   initial begin : result_sink
      int unsigned burst;
      int unsigned gap;
      @(negedge reset);
      forever begin
         if (!hold_off_done && readings_seen >= 400) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (burst) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      csc_request_type item;
      int unsigned     phase;
      int unsigned     sent;
      logic [11:0]     circ;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset circumference
      // first sample after reset, then a timeout with nothing to clear
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd0, 16'd0, 1, 16'd0, 16'd0, 1, 1, 0, 0, 0);
      add_row(csc_pkg::REQ_TIMEOUT, 0, 32'd0, 16'd0, 0, 16'd0, 16'd0, 1, 0, 0, 0, 0);
      // one revolution each in one second
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd1, 16'd1024, 1, 16'd1, 16'd1024,
              0, 0, 0, 0, 0);
      // unchanged event times
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd5, 16'd1024, 1, 16'd3, 16'd1024,
              1, 1, 0, 0, 0);
      // garbage deltas
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd100005, 16'd2048, 1, 16'd2003, 16'd2048,
              1, 1, 0, 0, 0);
      // largest deltas that pass, one tick: both saturate
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd200004, 16'd2049, 1, 16'd4002, 16'd2049,
              1, 1, 16'hFFFF, 16'hFFFF, 0);
      // no wheel or crank data holds the last values
      add_row(csc_pkg::REQ_SAMPLE, 0, '1, '1, 0, '1, '1, 1, 1, 16'hFFFF, 16'hFFFF, 0);
      // timeout zeroes, a second one has nothing to do
      add_row(csc_pkg::REQ_TIMEOUT, 1, '1, '1, 1, '1, '1, 1, 1, 0, 0, 1);
      add_row(csc_pkg::REQ_TIMEOUT, 0, 32'd0, 16'd0, 0, 16'd0, 16'd0, 1, 0, 0, 0, 0);
      // first sample after timeout at the all-ones counters
      add_row(csc_pkg::REQ_SAMPLE, 1, '1, '1, 1, '1, '1, 1, 1, 0, 0, 0);
      // counters and times wrap
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd2, 16'h0400, 1, 16'd1, 16'h03FF,
              0, 0, 0, 0, 0);
      // longest time delta
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd3, 16'h03FF, 1, 16'd2, 16'h03FE,
              0, 0, 0, 0, 0);
      // session reset forgets history
      add_row(csc_pkg::REQ_SESSION_RESET, 1, '1, '1, 1, '1, '1, 1, 0, 0, 0, 0);
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd10, 16'd100, 1, 16'd10, 16'd100,
              1, 1, 0, 0, 0);
      // undefined request code is dropped
      add_row(REQ_UNDEFINED, 1, '1, '1, 1, '1, '1, 1, 0, 0, 0, 0);
      // wheel only, then crank only
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd12, 16'd612, 0, '1, '1, 0, 0, 0, 0, 0);
      add_row(csc_pkg::REQ_SAMPLE, 0, '1, '1, 1, 16'd12, 16'd356, 0, 0, 0, 0, 0);
      // timeout after a session reset still zeroes
      add_row(csc_pkg::REQ_SESSION_RESET, 0, 32'd0, 16'd0, 0, 16'd0, 16'd0,
              1, 0, 0, 0, 0);
      add_row(csc_pkg::REQ_TIMEOUT, 0, 32'd0, 16'd0, 0, 16'd0, 16'd0, 1, 1, 0, 0, 1);
      add_row(csc_pkg::REQ_SAMPLE, 0, 32'd0, 16'd0, 0, 16'd0, 16'd0, 1, 1, 0, 0, 0);
      // garbage limits exactly, then one revolution per tick
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd0, 16'd0, 1, 16'd0, 16'd0, 1, 1, 0, 0, 0);
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd100000, 16'd10, 1, 16'd2000, 16'd10,
              1, 1, 0, 0, 0);
      add_row(csc_pkg::REQ_SAMPLE, 1, 32'd100001, 16'd11, 1, 16'd2001, 16'd11,
              1, 1, 16'hFFFF, 16'hFFFF, 0);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed,
                       directed_rows[i].count, directed_rows[i].res);

      // random phases, each at its own circumference
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            circ = 12'd500;
         else if (phase == 1)
            circ = 12'd4000;
         else
            circ = 12'($urandom_range(500, 4000));
         write_circumference(circ);
         no_gaps = (phase == 3);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            make_random_request(item);
            offer_request(item, 1'b0, 0, '0);
            if (item.kind != REQ_UNDEFINED)
               sent++;
            if (phase == 2 && sent == ITEMS_PER_PHASE / 2)
               wait_until_drained();
         end
      end
      no_gaps = 1'b0;

      // drain and report
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time,
                  expected_readings.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
